### sv/grid_graph_edge_weight_builder_assert.svh
// -----------------------------------------------------------------------------
// Assertion macros for the grid graph edge builder
// Clocked property checks; define NO_ASSERTIONS to compile them out.
// -----------------------------------------------------------------------------
`ifndef GRID_GRAPH_EDGE_WEIGHT_BUILDER_ASSERT_SVH
`define GRID_GRAPH_EDGE_WEIGHT_BUILDER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset
`define GGEWB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property on every clock edge, reset included
`define GGEWB_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define GGEWB_ASSERT(label, clk, rst_n, prop, msg)
`define GGEWB_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

### sv/ggewb_pkg.sv
// -----------------------------------------------------------------------------
// ggewb_pkg
// Types, constants and control codes shared by the grid graph edge builder.
// -----------------------------------------------------------------------------
package ggewb_pkg;

    localparam int MAX_COLS_DEF = 256;
    localparam int MAX_ROWS_DEF = 256;

    localparam int CELL_W   = 16;
    localparam int NODE_W   = 16;
    localparam int SUM_W    = 17;
    localparam int REC_W    = 33;
    localparam int GRID_W_W = 9;

    localparam logic [GRID_W_W-1:0] GRID_W_RESET = 9'd256;

    // 2^33 / sum: 34 dividend bits, one per step
    localparam int DIV_STEPS = REC_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register index taken from the word address bits
    localparam logic [PADDR_W-3:0] REG_GRID_WIDTH = 1'b0;

    typedef enum logic [1:0] {
        EDGE_LEFT,
        EDGE_UP_LEFT,
        EDGE_UP,
        EDGE_UP_RIGHT
    } t_edge;

    localparam int NUM_EDGES = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_UP,
        ST_RD_UR,
        ST_UPDATE,
        ST_START,
        ST_DIV,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic [CELL_W-1:0] cell_weight;
        logic              frame_start;
    } t_in_item;

    typedef struct packed {
        logic [NODE_W-1:0] from_node;
        logic [NODE_W-1:0] to_node;
        logic [SUM_W-1:0]  weight_halves;
        logic [REC_W-1:0]  reciprocal_weight;
        logic              last_edge;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic rd_up;
        logic rd_ur;
        logic update;
        logic start;
        logic step;
        logic push;
    } t_dp_cmd;

    typedef struct packed {
        logic drop;
        logic any_edge;
        logic div_done;
        logic out_free;
        logic more;
    } t_dp_status;

endpackage

### sv/grid_graph_edge_weight_builder.sv
// -----------------------------------------------------------------------------
// grid_graph_edge_weight_builder
// Takes grid cell weights in raster order (column fastest, a weight of zero
// marks a blocked cell) and emits, for each open cell, one edge request per
// open 8-connected neighbour seen earlier, in the order left, up-left, up,
// up-right. Each edge carries both node indices (column + row * width, 16 bits),
// the weight sum in halves and floor(2^33 / sum), the reciprocal average in
// Q.32; last_edge flags the final edge of a cell. A cell inside the grid goes
// through accept, two reads of the previous-row store and a state update, then
// for each edge it produces operand select, 34 steps of the single shared
// radix-2 divider and hand-off. A cell dropped past the last row goes no
// further than its accept step. The output register holds one edge while the
// next one is divided, so an output stall delays a hand-off only by the part
// of it that outlasts that divide. A frame_start request restarts the grid at
// column 0, row 0; cells past MAX_ROWS rows are dropped until the next
// frame_start. The previous-row store is not cleared at reset: the first row
// of a grid fills it before any read relies on it. grid_width (register 0 at
// byte address 0) selects the columns per row; 0 counts as 1, values above
// MAX_COLS as MAX_COLS. Write it only while idle.
// -----------------------------------------------------------------------------
module grid_graph_edge_weight_builder #(
    parameter int MAX_COLS = ggewb_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = ggewb_pkg::MAX_ROWS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input requests: one grid cell each
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  ggewb_pkg::t_in_item            i_in_item,
    // output requests: one edge each
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output ggewb_pkg::t_out_item           o_out_item,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ggewb_pkg::PADDR_W-1:0]  paddr,
    input  logic [ggewb_pkg::PDATA_W-1:0]  pwdata,
    output logic [ggewb_pkg::PDATA_W-1:0]  prdata,
    output logic                           pready
);

    import ggewb_pkg::*;

    // Configuration register: write in the access phase, pready held high
    logic [GRID_W_W-1:0] r_grid_width;
    logic                cfg_sel;

    assign cfg_sel = (paddr[PADDR_W-1:2] == REG_GRID_WIDTH);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width <= GRID_W_RESET;
        end else if (psel && penable && pwrite && pready && cfg_sel) begin
            r_grid_width <= pwdata[GRID_W_W-1:0];
        end
    end

    // Return the register on its address, zero elsewhere
    assign prdata = cfg_sel ? PDATA_W'(r_grid_width) : '0;

    // Controller and datapath talk only through command and status
    t_dp_cmd    cmd;
    t_dp_status status;

    ggewb_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_status  (status),
        .o_cmd     (cmd),
        .o_in_stall(o_in_stall)
    );

    ggewb_dp #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grid_width(r_grid_width),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

### sv/ggewb_ram.sv
// -----------------------------------------------------------------------------
// ggewb_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// -----------------------------------------------------------------------------
module ggewb_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/ggewb_ctrl.sv
// -----------------------------------------------------------------------------
// ggewb_ctrl
// Sequencer: row store reads, state update, then one divide per edge.
// -----------------------------------------------------------------------------
module ggewb_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  ggewb_pkg::t_dp_status i_status,
    output ggewb_pkg::t_dp_cmd    o_cmd,
    output logic                  o_in_stall
);

    import ggewb_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
                if (i_in_valid && !i_status.drop) begin
                    n_state = ST_RD_UP;
                end
            end
            ST_RD_UP: begin
                o_cmd.rd_up = 1'b1;
                n_state     = ST_RD_UR;
            end
            ST_RD_UR: begin
                o_cmd.rd_ur = 1'b1;
                n_state     = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = i_status.any_edge ? ST_START : ST_IDLE;
            end
            ST_START: begin
                o_cmd.start = 1'b1;
                n_state     = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
                if (i_status.div_done) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = i_status.more ? ST_START : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/ggewb_dp.sv
// -----------------------------------------------------------------------------
// ggewb_dp
// Datapath: grid position, row store, edge selection, radix-2 divider and
// output register.
// -----------------------------------------------------------------------------
`include "grid_graph_edge_weight_builder_assert.svh"

module ggewb_dp #(
    parameter int MAX_COLS = ggewb_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = ggewb_pkg::MAX_ROWS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [ggewb_pkg::GRID_W_W-1:0]    i_grid_width,
    input  ggewb_pkg::t_in_item               i_in_item,
    input  ggewb_pkg::t_dp_cmd                i_cmd,
    output ggewb_pkg::t_dp_status             o_status,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output ggewb_pkg::t_out_item              o_out_item
);

    import ggewb_pkg::*;

    localparam int CW = $clog2(MAX_COLS);
    localparam int XW = CW + 1;
    localparam int WW = $clog2(MAX_COLS + 1);
    localparam int RW = $clog2(MAX_ROWS + 1);
    localparam int TW = (WW > GRID_W_W) ? WW : GRID_W_W;
    localparam int PW = RW + WW;

    // Width in use
    logic [TW-1:0] gw_ext;
    logic [WW-1:0] w;
    logic [XW-1:0] w_x;

    always_comb begin
        gw_ext = TW'(i_grid_width);
        if (gw_ext == '0) begin
            w = WW'(1);
        end else if (gw_ext > TW'(MAX_COLS)) begin
            w = WW'(MAX_COLS);
        end else begin
            w = WW'(gw_ext);
        end
        w_x = XW'(w);
    end

    // Position state
    logic [CW-1:0]     r_column;
    logic [RW-1:0]     r_row;
    logic [CELL_W-1:0] r_left;
    logic [CELL_W-1:0] r_ul;
    logic [CELL_W-1:0] r_cur;
    logic [CELL_W-1:0] r_up;
    logic [NODE_W-1:0] r_base;
    logic [NODE_W-1:0] r_here;

    // Frame restart and row wrap ahead of the cell
    logic [CW-1:0]     c0;
    logic [RW-1:0]     r0;
    logic [CELL_W-1:0] l0;
    logic [CELL_W-1:0] u0;
    logic              ign;
    logic              wrap;
    logic [CW-1:0]     c1;
    logic [RW-1:0]     r1;

    always_comb begin
        c0   = i_in_item.frame_start ? '0 : r_column;
        r0   = i_in_item.frame_start ? '0 : r_row;
        l0   = i_in_item.frame_start ? '0 : r_left;
        u0   = i_in_item.frame_start ? '0 : r_ul;
        ign  = (r0 >= RW'(MAX_ROWS));
        wrap = !ign && (XW'(c0) >= w_x);
        c1   = wrap ? '0 : c0;
        r1   = wrap ? RW'(r0 + RW'(1)) : r0;
    end

    // Row store
    logic [CW-1:0]     rd_addr;
    logic [CELL_W-1:0] ram_rdata;
    logic [XW-1:0]     col_inc;

    assign col_inc = XW'(r_column) + XW'(1);
    assign rd_addr = i_cmd.rd_ur ? CW'(col_inc) : r_column;

    ggewb_ram #(
        .DATA_W(CELL_W),
        .DEPTH (MAX_COLS)
    ) u_row_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.update),
        .i_waddr(r_column),
        .i_wdata(r_cur),
        .i_raddr(rd_addr),
        .o_rdata(ram_rdata)
    );

    logic [PW-1:0] prod;
    assign prod = PW'(r_row) * PW'(w);

    // Edges present for this cell
    logic [NUM_EDGES-1:0] mask_new;
    logic                 cur_nz;
    logic                 col_nz;
    logic                 row_nz;

    always_comb begin
        cur_nz = (r_cur != '0);
        col_nz = (r_column != '0);
        row_nz = (r_row != '0);
        mask_new[EDGE_LEFT]     = cur_nz && col_nz && (r_left != '0);
        mask_new[EDGE_UP_LEFT]  = cur_nz && row_nz && col_nz && (r_ul != '0);
        mask_new[EDGE_UP]       = cur_nz && row_nz && (r_up != '0);
        mask_new[EDGE_UP_RIGHT] = cur_nz && row_nz && (col_inc < w_x)
                                  && (ram_rdata != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= '0;
            r_row    <= '0;
            r_left   <= '0;
            r_ul     <= '0;
        end else if (i_cmd.accept) begin
            r_column <= c1;
            r_row    <= r1;
            r_left   <= l0;
            r_ul     <= u0;
        end else if (i_cmd.update) begin
            if (col_inc >= w_x) begin
                r_column <= '0;
                r_row    <= RW'(r_row + RW'(1));
                r_left   <= '0;
                r_ul     <= '0;
            end else begin
                r_column <= CW'(col_inc);
                r_left   <= r_cur;
                r_ul     <= r_up;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cur <= i_in_item.cell_weight;
        end
        if (i_cmd.rd_up) begin
            r_base <= NODE_W'(prod);
        end
        if (i_cmd.rd_ur) begin
            r_up   <= ram_rdata;
            r_here <= r_base + NODE_W'(r_column);
        end
    end

    // Edge operands and pending set
    logic [CELL_W-1:0]    r_opnd [NUM_EDGES];
    logic [NUM_EDGES-1:0] r_mask;
    t_edge                r_sel;
    t_edge                sel_next;
    logic [NUM_EDGES-1:0] sel_bit;
    logic [NUM_EDGES-1:0] mask_rest;

    always_comb begin
        if (r_mask[EDGE_LEFT]) begin
            sel_next = EDGE_LEFT;
        end else if (r_mask[EDGE_UP_LEFT]) begin
            sel_next = EDGE_UP_LEFT;
        end else if (r_mask[EDGE_UP]) begin
            sel_next = EDGE_UP;
        end else begin
            sel_next = EDGE_UP_RIGHT;
        end
        sel_bit   = NUM_EDGES'(1) << r_sel;
        mask_rest = r_mask & ~sel_bit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_cmd.update) begin
            r_mask <= mask_new;
        end else if (i_cmd.push) begin
            r_mask <= mask_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_opnd[EDGE_LEFT]     <= r_left;
            r_opnd[EDGE_UP_LEFT]  <= r_ul;
            r_opnd[EDGE_UP]       <= r_up;
            r_opnd[EDGE_UP_RIGHT] <= ram_rdata;
        end
        if (i_cmd.start) begin
            r_sel <= sel_next;
        end
    end

    // Restoring radix-2 divider for 2^33 / sum, one quotient bit per step
    logic [SUM_W-1:0]     r_sum;
    logic [SUM_W-1:0]     r_rem;
    logic [DIV_STEPS-1:0] r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [SUM_W:0]       trial;
    logic                 fits;

    always_comb begin
        trial = {r_rem, (r_cnt == '0)};
        fits  = (trial >= {1'b0, r_sum});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_sum <= SUM_W'(r_cur) + SUM_W'(r_opnd[sel_next]);
            r_rem <= '0;
            r_quo <= '0;
            r_cnt <= '0;
        end else if (i_cmd.step) begin
            r_rem <= fits ? SUM_W'(trial - {1'b0, r_sum}) : SUM_W'(trial);
            r_quo <= {r_quo[DIV_STEPS-2:0], fits};
            r_cnt <= DIV_CNT_W'(r_cnt + DIV_CNT_W'(1));
        end
    end

    // Output register
    logic [NODE_W-1:0] w16;
    t_out_item         out_next;
    t_out_item         r_out_item;
    logic              r_out_valid;

    assign w16 = NODE_W'(w);

    always_comb begin
        out_next.from_node         = r_here;
        out_next.weight_halves     = r_sum;
        out_next.reciprocal_weight = r_quo[REC_W-1:0];
        out_next.last_edge         = (mask_rest == '0);
        case (r_sel)
            EDGE_LEFT:     out_next.to_node = r_here - NODE_W'(1);
            EDGE_UP_LEFT:  out_next.to_node = r_here - w16 - NODE_W'(1);
            EDGE_UP:       out_next.to_node = r_here - w16;
            EDGE_UP_RIGHT: out_next.to_node = r_here - w16 + NODE_W'(1);
            default:       out_next.to_node = r_here;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_item <= out_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        o_status.drop     = ign || (r1 >= RW'(MAX_ROWS));
        o_status.any_edge = (mask_new != '0);
        o_status.div_done = (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));
        o_status.out_free = !r_out_valid || !i_out_stall;
        o_status.more     = (mask_rest != '0);
    end

    `GGEWB_ASSERT(a_push_free, i_clk, i_rst_n, i_cmd.push |-> o_status.out_free, "push into a held output")
    `GGEWB_ASSERT(a_quo_fits, i_clk, i_rst_n, i_cmd.push |-> !r_quo[DIV_STEPS-1], "quotient overflow")
    `GGEWB_ASSERT(a_sum_min, i_clk, i_rst_n, i_cmd.push |-> (r_sum > SUM_W'(1)), "weight sum below two")
    `GGEWB_ASSERT(a_mask_open, i_clk, i_rst_n, (r_mask != '0) |-> (r_cur != '0), "edges for a blocked cell")

endmodule
